// File: rtl/mexp_pkg.sv
// Shared constants and types for the modular exponentiation block.
// No dependencies; compiled first.
`default_nettype none

package mexp_pkg;

  localparam int unsigned BASE_W   = 32;
  localparam int unsigned EXP_BITS = 32;
  localparam int unsigned MOD_BITS = 31;
  localparam int unsigned CNT_W    = $clog2(BASE_W);

  localparam logic [MOD_BITS-1:0] MODULUS_RESET = MOD_BITS'(5318008);

  // Request to the shared modular multiplier: product = (a * b) mod m, b below m.
  typedef struct packed {
    logic                start;
    logic [BASE_W-1:0]   a;
    logic [MOD_BITS-1:0] b;
  } mexp_mm_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [MOD_BITS-1:0] product;
  } mexp_mm_sts_t;

endpackage

`default_nettype wire

// File: rtl/mexp_if.sv
// Valid/ready channel interfaces for the modular exponentiation block.
// Depends on mexp_pkg for field widths.
`default_nettype none

interface mexp_in_if;
  import mexp_pkg::*;

  logic                valid;
  logic                ready;
  logic [BASE_W-1:0]   base;
  logic [BASE_W-1:0]   exponent;

  modport source (output valid, output base, output exponent, input ready);
  modport sink   (input valid, input base, input exponent, output ready);
endinterface

interface mexp_out_if;
  import mexp_pkg::*;

  logic                valid;
  logic                ready;
  logic [MOD_BITS-1:0] power;

  modport source (output valid, output power, input ready);
  modport sink   (input valid, input power, output ready);
endinterface

`default_nettype wire

// File: rtl/mexp_mulmod.sv
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle, MSB first.
// Depends on mexp_pkg.
`default_nettype none

module mexp_mulmod (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [mexp_pkg::MOD_BITS-1:0] mod_i,
  input  wire mexp_pkg::mexp_mm_req_t        req_i,
  output      mexp_pkg::mexp_mm_sts_t        sts_o
);
  import mexp_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [BASE_W-1:0]   a_q, a_d;
  logic [MOD_BITS-1:0] b_q, b_d;
  logic [MOD_BITS-1:0] r_q, r_d;

  logic [MOD_BITS:0]   m_ext;
  logic [MOD_BITS:0]   dbl, dbl_red, acc, acc_red;

  // One step: r = (2r + bit*b) mod m, each partial sum stays below 2m.
  always_comb begin
    m_ext   = {1'b0, mod_i};
    dbl     = {r_q, 1'b0};
    dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
    acc     = dbl_red + (a_q[BASE_W-1] ? {1'b0, b_q} : '0);
    acc_red = (acc >= m_ext) ? acc - m_ext : acc;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    r_d    = r_q;
    if (busy_q) begin
      r_d   = acc_red[MOD_BITS-1:0];
      a_d   = {a_q[BASE_W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(BASE_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d    = req_i.a;
      b_d    = req_i.b;
      r_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    r_q <= r_d;
  end

  assign sts_o.busy    = busy_q;
  assign sts_o.done    = done_q;
  assign sts_o.product = r_q;

endmodule

`default_nettype wire

// File: rtl/modular_exponentiation.sv
// Top level: right-to-left square-and-multiply sequencer around mexp_mulmod.
// Depends on mexp_pkg, mexp_if and mexp_mulmod.
//
//   port        dir   kind        payload
//   in_i        sink  valid/ready base[31:0], exponent[31:0]
//   out_o       src   valid/ready power[30:0]
//   cfg_we_i    in    write       cfg_wdata_i[30:0] -> modulus
//
// Each modular product runs through the 32 multiplier bits in the single bit-serial
// multiplier, which then raises done. An item costs one base reduction, then per
// exponent bit up to the highest set bit one square and, for a set bit, one multiply.
// The next item can be taken in the same cycle that the valid result appears.
// Input is taken only while the sequencer is idle; a finished result waits in
// the output register, and the block stalls only if a new result is ready first.
// Reset loads the modulus with 5318008 and leaves the block idle.
`default_nettype none

module modular_exponentiation (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mexp_pkg::MOD_BITS-1:0] cfg_wdata_i,
  mexp_in_if.sink                            in_i,
  mexp_out_if.source                         out_o
);
  import mexp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_BIT  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_SQR  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [MOD_BITS-1:0] mod_q;
  logic [MOD_BITS-1:0] m_eff;
  logic [EXP_BITS-1:0] exp_q, exp_d;
  logic [MOD_BITS-1:0] base_q, base_d;
  logic [MOD_BITS-1:0] res_q, res_d;
  logic                ovalid_q, ovalid_d;
  logic [MOD_BITS-1:0] power_q, power_d;

  mexp_mm_req_t mm_req;
  mexp_mm_sts_t mm_sts;

  // A zero modulus acts as one.
  assign m_eff = (mod_q == '0) ? MOD_BITS'(1) : mod_q;

  mexp_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mod_i  (m_eff),
    .req_i  (mm_req),
    .sts_o  (mm_sts)
  );

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = ovalid_q;
  assign out_o.power = power_q;

  always_comb begin
    state_d  = state_q;
    exp_d    = exp_q;
    base_d   = base_q;
    res_d    = res_q;
    ovalid_d = ovalid_q && !out_o.ready;
    power_d  = power_q;
    mm_req   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          // Reduce the base as base * 1 mod m.
          mm_req.start = 1'b1;
          mm_req.a     = in_i.base;
          mm_req.b     = (m_eff == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
          exp_d        = in_i.exponent[EXP_BITS-1:0];
          res_d        = MOD_BITS'(1);
          state_d      = S_RED;
        end
      end
      S_RED: begin
        if (mm_sts.done) begin
          base_d  = mm_sts.product;
          state_d = S_BIT;
        end
      end
      S_BIT: begin
        if (exp_q == '0) begin
          state_d = S_FIN;
        end else begin
          mm_req.start = 1'b1;
          mm_req.a     = BASE_W'(exp_q[0] ? res_q : base_q);
          mm_req.b     = base_q;
          state_d      = exp_q[0] ? S_MUL : S_SQR;
        end
      end
      S_MUL: begin
        if (mm_sts.done) begin
          res_d        = mm_sts.product;
          mm_req.start = 1'b1;
          mm_req.a     = BASE_W'(base_q);
          mm_req.b     = base_q;
          state_d      = S_SQR;
        end
      end
      S_SQR: begin
        if (mm_sts.done) begin
          base_d  = mm_sts.product;
          exp_d   = exp_q >> 1;
          state_d = S_BIT;
        end
      end
      S_FIN: begin
        // Hold until the output register is free.
        if (!ovalid_q || out_o.ready) begin
          ovalid_d = 1'b1;
          power_d  = res_q;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
      mod_q    <= MODULUS_RESET;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        mod_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q   <= exp_d;
    base_q  <= base_d;
    res_q   <= res_d;
    power_q <= power_d;
  end

  // The multiplier is never restarted while it still works.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_req.start |-> !mm_sts.busy)
    else $error("multiplier started while busy");

  // A finished product only arrives while the sequencer waits for one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_sts.done |-> (state_q == S_RED || state_q == S_MUL || state_q == S_SQR))
    else $error("product arrived outside a wait state");

  // Each square consumes exactly one exponent bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SQR && mm_sts.done) |=> (exp_q == ($past(exp_q) >> 1)))
    else $error("exponent not shifted after square");

  // A delivered power is reduced, except the unreduced one of a zero exponent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.power < m_eff || out_o.power == MOD_BITS'(1)))
    else $error("power not reduced");

endmodule

`default_nettype wire
